### rtl/core/lcf_pkg.sv
package lcf_pkg;

	localparam logic [7:0]  START_BYTE = 8'h02;
	localparam logic [7:0]  CMD_BYTE   = 8'h05;
	localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// position of the held transaction within its burst of output bytes
	typedef enum logic [3:0] {
		PH_FIRST,
		PH_CMD,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_DATA,
		PH_CRC3,
		PH_CRC2,
		PH_CRC1,
		PH_CRC0
	} phase_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        run_end;
		logic        frame_end;
		logic        done;
		phase_t      next_phase;
		logic [31:0] crc_next;
		logic        inside_next;
	} emit_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### rtl/core/lcf_emit.sv
module lcf_emit import lcf_pkg::*; (
	input  logic [7:0]  data_byte,
	input  logic        frame_kind,
	input  logic [15:0] payload_length,
	input  logic        last_byte,
	input  phase_t      phase,
	input  logic [31:0] crc,
	input  logic        frame_open,
	output emit_t       em
);

	logic [31:0] crc_out;
	logic        take_data;

	assign crc_out = ~crc;
	// a fresh transaction inside an open frame goes straight to its payload byte
	assign take_data = (phase == PH_DATA) || (phase == PH_FIRST && frame_open);

	always_comb begin
		em             = '0;
		em.next_phase  = phase;
		em.crc_next    = crc;
		em.inside_next = frame_open;
		if (take_data) begin
			em.out_byte   = data_byte;
			em.crc_next   = crc_byte(crc, data_byte);
			em.run_end    = ~last_byte;
			em.done       = ~last_byte;
			em.next_phase = PH_CRC3;
		end else begin
			case (phase)
				PH_FIRST: begin
					em.out_byte    = START_BYTE;
					em.crc_next    = crc_byte(CRC_INIT, START_BYTE);
					em.inside_next = 1'b1;
					em.next_phase  = (frame_kind == KIND_CMD) ? PH_CMD : PH_DATA;
				end
				PH_CMD: begin
					em.out_byte   = CMD_BYTE;
					em.crc_next   = crc_byte(crc, CMD_BYTE);
					em.next_phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					em.out_byte   = payload_length[15:8];
					em.crc_next   = crc_byte(crc, payload_length[15:8]);
					em.next_phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					em.out_byte   = payload_length[7:0];
					em.crc_next   = crc_byte(crc, payload_length[7:0]);
					em.next_phase = PH_DATA;
				end
				PH_CRC3: begin
					em.out_byte   = crc_out[31:24];
					em.next_phase = PH_CRC2;
				end
				PH_CRC2: begin
					em.out_byte   = crc_out[23:16];
					em.next_phase = PH_CRC1;
				end
				PH_CRC1: begin
					em.out_byte   = crc_out[15:8];
					em.next_phase = PH_CRC0;
				end
				PH_CRC0: begin
					em.out_byte    = crc_out[7:0];
					em.run_end     = 1'b1;
					em.frame_end   = 1'b1;
					em.done        = 1'b1;
					em.crc_next    = CRC_INIT;
					em.inside_next = 1'b0;
				end
				default: begin
					em.next_phase = PH_FIRST;
				end
			endcase
		end
	end

endmodule

### rtl/core/lcf_out_reg.sv
module lcf_out_reg import lcf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic [7:0] byte_d,
	input  logic       run_end_d,
	input  logic       frame_end_d,
	output logic       advance,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       frame_end
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_end_q;
	logic       frame_end_q;

	// register may take a new byte when empty or when its byte leaves now
	assign advance = ~valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			byte_q      <= byte_d;
			run_end_q   <= run_end_d;
			frame_end_q <= frame_end_d;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign run_end   = run_end_q;
	assign frame_end = frame_end_q;

endmodule

### rtl/core/stx_length_crc32_framer.sv
// An input transaction's first output byte passes the input register, then the output register.
// Throughput: one output byte per cycle when out_ready allows; a transaction stays in the input
//   register until all its bytes (1 to 9) are out, so in-frame payload bytes flow at one per cycle.
// The input register frees as its final byte moves into the output register, so the next
//   transaction is taken in that same cycle.
// Reset (arst_n, async, active low): both stages empty, CRC all ones, no frame open.
module stx_length_crc32_framer import lcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_kind,
	input  logic [15:0] payload_length,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_end,
	output logic        frame_end
);

	// input stage: the held transaction and where it stands in its burst
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        kind_s1;
	logic [15:0] len_s1;
	logic        last_s1;
	phase_t      phase_s1;

	// frame state
	logic [31:0] crc_q;
	logic        inside_q;

	emit_t em;
	logic  advance;
	logic  fire;
	logic  in_take;

	// a byte is produced whenever the input stage holds a transaction and the output
	// register can take it
	assign fire     = valid_s1 & advance;
	assign in_ready = ~valid_s1 | (fire & em.done);
	assign in_take  = in_valid & in_ready;

	lcf_emit u_emit (
		.data_byte      (data_s1),
		.frame_kind     (kind_s1),
		.payload_length (len_s1),
		.last_byte      (last_s1),
		.phase          (phase_s1),
		.crc            (crc_q),
		.frame_open     (inside_q),
		.em             (em)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= PH_FIRST;
			crc_q    <= CRC_INIT;
			inside_q <= 1'b0;
		end else begin
			if (fire) begin
				crc_q    <= em.crc_next;
				inside_q <= em.inside_next;
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
				phase_s1 <= PH_FIRST;
			end else if (fire) begin
				if (em.done) begin
					valid_s1 <= 1'b0;
				end else begin
					phase_s1 <= em.next_phase;
				end
			end
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			kind_s1 <= frame_kind;
			len_s1  <= payload_length;
			last_s1 <= last_byte;
		end
	end

	lcf_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (valid_s1),
		.byte_d      (em.out_byte),
		.run_end_d   (em.run_end),
		.frame_end_d (em.frame_end),
		.advance     (advance),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.run_end     (run_end),
		.frame_end   (frame_end)
	);

endmodule
